>>> rtl/isaac_pkg.sv
// Shared types and constants for the ISAAC generator.
package isaac_pkg;
  localparam int unsigned TableWords = 256;
  localparam logic [31:0] Golden = 32'h9e3779b9;

  typedef enum logic [1:0] {
    REQ_SEED = 2'd0,
    REQ_INIT = 2'd1,
    REQ_NEXT = 2'd2,
    REQ_NONE = 2'd3
  } req_e;

  typedef struct packed {
    req_e        kind;
    logic [7:0]  index;
    logic [31:0] word;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEED,
    ST_MROUND,
    ST_PLOAD,
    ST_PMIX,
    ST_PSTORE,
    ST_RSTART,
    ST_RA,
    ST_RB,
    ST_RC,
    ST_RD,
    ST_OREAD,
    ST_OSHOW,
    ST_CLEAR
  } state_e;

  // One step of the eight-word mix: step s (0..7) updates v[s], v[s+3], v[s+1].
  function automatic logic [255:0] mix_step(input logic [255:0] vi, input logic [2:0] s);
    logic [31:0] v [8];
    logic [31:0] t;
    logic [2:0] i0, i1, i2, i3;
    for (int k = 0; k < 8; k++) v[k] = vi[k*32 +: 32];
    i0 = s; i1 = s + 3'd1; i2 = s + 3'd2; i3 = s + 3'd3;
    case (s)
      3'd0: t = v[i1] << 11;
      3'd1: t = v[i1] >> 2;
      3'd2: t = v[i1] << 8;
      3'd3: t = v[i1] >> 16;
      3'd4: t = v[i1] << 10;
      3'd5: t = v[i1] >> 4;
      3'd6: t = v[i1] << 8;
      default: t = v[i1] >> 9;
    endcase
    v[i0] = v[i0] ^ t;
    v[i3] = v[i3] + v[i0];
    v[i1] = v[i1] + v[i2];
    mix_step = '0;
    for (int k = 0; k < 8; k++) mix_step[k*32 +: 32] = v[k];
  endfunction
endpackage

>>> rtl/isaac_front.sv
// Input stage and two-entry command queue.
module isaac_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          req_type_i,
  input  logic [7:0]          seed_index_i,
  input  logic [31:0]         seed_word_i,
  output logic                cmd_valid_o,
  input  logic                cmd_take_i,
  output isaac_pkg::cmd_t     cmd_o
);
  import isaac_pkg::*;
  cmd_t q_q [2];
  logic rd_q, wr_q;
  logic [1:0] cnt_q;
  logic push;
  assign in_stall = (cnt_q == 2'd2);
  assign push = in_valid && !in_stall && (req_type_i != REQ_NONE);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o = q_q[rd_q];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q <= 1'b0; wr_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (cmd_take_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, cmd_take_i};
    end
  end
  always_ff @(posedge clk_i) begin
    if (push) q_q[wr_q] <= '{kind: req_e'(req_type_i), index: seed_index_i, word: seed_word_i};
  end
endmodule

>>> rtl/isaac_back.sv
// Sequencer, tables and output register.
module isaac_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cmd_valid_i,
  output logic            cmd_take_o,
  input  isaac_pkg::cmd_t cmd_i,
  input  logic [8:0]      seed_words_i,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [31:0]     random_word_o
);
  import isaac_pkg::*;
  logic [31:0] rmem [TableWords];
  logic [31:0] mmem [TableWords];
  state_e st_q, st_d;
  logic [8:0]  cl_q;
  logic [8:0]  i_q;     // table index / pass counter
  logic [4:0]  mc_q;    // mix round step counter
  logic        pass_q;
  logic [2:0]  k_q;
  logic [255:0] v_q, v_last;
  logic [31:0] a_q, b_q, c_q, x_q, y_q, y_d, m_fwd, rd_r, rd_m;
  logic [8:0]  pos_q;
  logic [31:0] out_q;
  logic        ov_q;
  logic [7:0]  raddr, maddr;
  logic        rwe, mwe;
  logic [7:0]  rwa, mwa;
  logic [31:0] rwd, mwd, amix, seedv_d1, ld_word;
  logic [7:0]  ii, ld_q;
  assign ii = i_q[7:0];
  assign out_valid = ov_q;
  assign random_word_o = out_q;

  always_comb begin
    case (ii[1:0])
      2'd0: amix = a_q ^ (a_q << 13);
      2'd1: amix = a_q ^ (a_q >> 6);
      2'd2: amix = a_q ^ (a_q << 2);
      default: amix = a_q ^ (a_q >> 16);
    endcase
  end

  // refill: new mix word, and the lookup it indexes (forwarded if it hits the same slot)
  assign y_d = rd_m + a_q + b_q;
  assign m_fwd = (y_q[17:10] == ii) ? y_q : rd_m;

  // next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_CLEAR: if (cl_q == 9'd255) st_d = ST_IDLE;
      ST_IDLE: if (cmd_valid_i && !(cmd_i.kind == REQ_NEXT && ov_q)) begin
        case (cmd_i.kind)
          REQ_SEED: st_d = ST_SEED;
          REQ_INIT: st_d = ST_MROUND;
          REQ_NEXT: st_d = (pos_q == 9'd0) ? ST_RSTART : ST_OREAD;
          default: st_d = ST_IDLE;
        endcase
      end
      ST_SEED: st_d = ST_IDLE;
      ST_MROUND: if (mc_q == 5'd31) st_d = ST_PLOAD;
      ST_PLOAD: if (k_q == 3'd7) st_d = ST_PMIX;
      ST_PMIX: if (mc_q[2:0] == 3'd7) st_d = ST_PSTORE;
      ST_PSTORE: if (k_q == 3'd7)
        st_d = (ii == 8'd248 && pass_q) ? ST_RSTART : ST_PLOAD;
      ST_RSTART: st_d = ST_RA;
      ST_RA: st_d = ST_RB;
      ST_RB: st_d = ST_RC;
      ST_RC: st_d = ST_RD;
      ST_RD: st_d = (ii == 8'd255) ? (cmd_i.kind == REQ_NEXT ? ST_OREAD : ST_IDLE) : ST_RA;
      ST_OREAD: st_d = ST_OSHOW;
      ST_OSHOW: st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  // outputs / addresses
  always_comb begin
    raddr = ii; maddr = ii; rwe = 1'b0; mwe = 1'b0;
    rwa = ii; mwa = ii; rwd = b_q; mwd = y_q;
    cmd_take_o = 1'b0;
    case (st_q)
      ST_CLEAR: begin rwe = 1'b1; mwe = 1'b1; rwa = cl_q[7:0]; mwa = cl_q[7:0];
        rwd = '0; mwd = '0; end
      ST_SEED: begin rwe = 1'b1; rwa = cmd_i.index; rwd = cmd_i.word; cmd_take_o = 1'b1; end
      ST_PLOAD: begin raddr = ii + {5'd0, k_q}; maddr = ii + {5'd0, k_q}; end
      ST_PSTORE: begin mwe = 1'b1; mwa = ii + {5'd0, k_q}; mwd = v_q[k_q*32 +: 32]; end
      ST_RA: maddr = ii + 8'd128;
      ST_RB: maddr = x_q[9:2];
      ST_RC: begin mwe = 1'b1; mwd = y_d; maddr = y_d[17:10]; end
      ST_RD: begin rwe = 1'b1; rwd = m_fwd + x_q; maddr = ii + 8'd1; end
      ST_RSTART: maddr = 8'd0;
      ST_OREAD: raddr = pos_q[7:0];
      ST_OSHOW: cmd_take_o = 1'b1;
      ST_IDLE: cmd_take_o = cmd_valid_i && cmd_i.kind != REQ_SEED && cmd_i.kind != REQ_INIT
                 && cmd_i.kind != REQ_NEXT;
      default: ;
    endcase
    if (st_q == ST_RD && ii == 8'd255 && cmd_i.kind != REQ_NEXT) cmd_take_o = 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (rwe) rmem[rwa] <= rwd;
    if (mwe) mmem[mwa] <= mwd;
    rd_r <= rmem[raddr];
    rd_m <= mmem[maddr];
  end

  // seed data arrives in the cycle after its address
  always_ff @(posedge clk_i) ld_q <= ii + {5'd0, k_q};
  assign seedv_d1 = ({1'b0, ld_q} < seed_words_i) ? rd_r : 32'd0;
  assign ld_word = pass_q ? rd_m : seedv_d1;

  always_comb begin
    v_last = v_q;
    v_last[255:224] = v_q[255:224] + ld_word;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_CLEAR; cl_q <= '0; i_q <= '0; mc_q <= '0; pass_q <= 1'b0; k_q <= '0;
      a_q <= '0; b_q <= '0; c_q <= '0; pos_q <= '0; ov_q <= 1'b0;
      v_q <= '0; x_q <= '0; y_q <= '0; out_q <= '0;
    end else begin
      st_q <= st_d;
      if (st_q == ST_OSHOW) ov_q <= 1'b1;
      else if (ov_q && !out_stall) ov_q <= 1'b0;
      case (st_q)
        ST_CLEAR: cl_q <= cl_q + 9'd1;
        ST_IDLE: begin
          if (st_d == ST_MROUND) begin
            v_q <= {8{Golden}}; a_q <= '0; b_q <= '0; c_q <= '0; mc_q <= '0;
          end
          if (st_d == ST_OREAD) pos_q <= pos_q - 9'd1;
        end
        ST_MROUND: begin
          v_q <= mix_step(v_q, mc_q[2:0]); mc_q <= mc_q + 5'd1;
          if (mc_q == 5'd31) begin i_q <= '0; k_q <= '0; pass_q <= 1'b0; end
        end
        ST_PLOAD: begin
          k_q <= k_q + 3'd1;
          // word k-1 lands now
          if (k_q != 3'd0)
            v_q[(k_q-3'd1)*32 +: 32] <= v_q[(k_q-3'd1)*32 +: 32] + ld_word;
        end
        ST_PMIX: begin
          // last loaded word lands as the mix begins
          v_q <= mix_step((mc_q[2:0] == 3'd0) ? v_last : v_q, mc_q[2:0]);
          mc_q <= mc_q + 5'd1;
        end
        ST_PSTORE: begin
          k_q <= k_q + 3'd1;
          if (k_q == 3'd7) begin
            if (ii == 8'd248) begin i_q <= '0; pass_q <= 1'b1; end
            else i_q <= i_q + 9'd8;
          end
        end
        ST_RSTART: begin c_q <= c_q + 32'd1; b_q <= b_q + c_q + 32'd1; i_q <= '0; end
        ST_RA: x_q <= rd_m;
        ST_RB: a_q <= amix + rd_m;
        ST_RC: y_q <= y_d;
        ST_RD: begin
          b_q <= m_fwd + x_q;
          i_q <= i_q + 9'd1;
          pos_q <= (cmd_i.kind == REQ_NEXT) ? 9'd255 : 9'd256;
        end
        ST_OSHOW: out_q <= rd_r;
        default: ;
      endcase
    end
  end
endmodule

>>> rtl/isaac_random_generator.sv
// Top level: ISAAC generator with APB config port.
// A seed write stores one word; initialize runs the mix rounds, two load/mix/store passes and a refill.
// Next waits while the output register still holds a word that has not drained;
// every 256th beat adds a table refill (states RA, RB, RC and RD for each word).
// After reset a pass over all 256 words clears both tables; no queued command is taken meanwhile.
module isaac_random_generator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  req_type_i,
  input  logic [7:0]  seed_index_i,
  input  logic [31:0] seed_word_i,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] random_word_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import isaac_pkg::*;
  logic [8:0] seed_words_q;
  logic cv, take;
  cmd_t cmd;
  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {23'd0, seed_words_q} : 32'd0;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) seed_words_q <= '0;
    else if (psel && penable && pwrite && paddr == 2'd0) seed_words_q <= pwdata[8:0];
  end
  isaac_front u_front (.clk_i, .rst_ni, .in_valid, .in_stall, .req_type_i, .seed_index_i,
    .seed_word_i, .cmd_valid_o(cv), .cmd_take_i(take), .cmd_o(cmd));
  isaac_back u_back (.clk_i, .rst_ni, .cmd_valid_i(cv), .cmd_take_o(take), .cmd_i(cmd),
    .seed_words_i(seed_words_q), .out_valid, .out_stall, .random_word_o);
endmodule

>>> test/tb.sv
// Testbench for the ISAAC random generator: directed and random requests against a predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import isaac_pkg::*;

  localparam logic [1:0] SeedWordsAddr = 2'd0;
  localparam int IdleLimit = 50000;
  localparam int DrainCycles = 10000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  req_e        req_type = REQ_NONE;
  logic [7:0]  seed_index = '0;
  logic [31:0] seed_word = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] random_word;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  isaac_random_generator i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .req_type_i(req_type), .seed_index_i(seed_index), .seed_word_i(seed_word),
    .out_valid(out_valid), .out_stall(out_stall), .random_word_o(random_word),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // generator state as predicted
  logic [31:0] res_tbl [256];
  logic [31:0] mix_tbl [256];
  logic [31:0] acc_a, prev_b, rounds;
  logic [31:0] mv [8];
  logic [8:0]  rd_pos, seed_len;

  logic [31:0] expected_words [$];
  int          errors = 0;
  bit          quiet = 1'b0;   // no idling on either side while set
  int          stall_left = 0;
  int          idle_cycles = 0;

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  function automatic void scramble_tables();
    logic [31:0] x, y;
    rounds = rounds + 1;
    prev_b = prev_b + rounds;
    for (int i = 0; i < 256; i++) begin
      x = mix_tbl[i];
      case (i & 3)
        0: acc_a = acc_a ^ (acc_a << 13);
        1: acc_a = acc_a ^ (acc_a >> 6);
        2: acc_a = acc_a ^ (acc_a << 2);
        default: acc_a = acc_a ^ (acc_a >> 16);
      endcase
      acc_a = acc_a + mix_tbl[(i + 128) & 255];
      y = mix_tbl[x[9:2]] + acc_a + prev_b;
      mix_tbl[i] = y;
      prev_b = mix_tbl[y[17:10]] + x;
      res_tbl[i] = prev_b;
    end
  endfunction

  function automatic void mix_round();
    mv[0] ^= mv[1] << 11; mv[3] += mv[0]; mv[1] += mv[2];
    mv[1] ^= mv[2] >> 2;  mv[4] += mv[1]; mv[2] += mv[3];
    mv[2] ^= mv[3] << 8;  mv[5] += mv[2]; mv[3] += mv[4];
    mv[3] ^= mv[4] >> 16; mv[6] += mv[3]; mv[4] += mv[5];
    mv[4] ^= mv[5] << 10; mv[7] += mv[4]; mv[5] += mv[6];
    mv[5] ^= mv[6] >> 4;  mv[0] += mv[5]; mv[6] += mv[7];
    mv[6] ^= mv[7] << 8;  mv[1] += mv[6]; mv[7] += mv[0];
    mv[7] ^= mv[0] >> 9;  mv[2] += mv[7]; mv[0] += mv[1];
  endfunction

  function automatic void seed_tables();
    int used;
    used = (seed_len > 256) ? 256 : seed_len;
    for (int k = 0; k < 8; k++) mv[k] = Golden;
    acc_a = '0;
    prev_b = '0;
    rounds = '0;
    for (int r = 0; r < 4; r++) mix_round();
    for (int pass = 0; pass < 2; pass++) begin
      for (int i = 0; i < 256; i += 8) begin
        for (int k = 0; k < 8; k++) begin
          if (pass == 1) mv[k] += mix_tbl[i + k];
          else if (i + k < used) mv[k] += res_tbl[i + k];
        end
        mix_round();
        for (int k = 0; k < 8; k++) mix_tbl[i + k] = mv[k];
      end
    end
    scramble_tables();
    rd_pos = 9'd256;
  endfunction

  function automatic void predict_request(input req_e kind, input logic [7:0] idx,
                                          input logic [31:0] word);
    case (kind)
      REQ_SEED: res_tbl[idx] = word;
      REQ_INIT: seed_tables();
      REQ_NEXT: begin
        if (rd_pos == 0) begin
          scramble_tables();
          rd_pos = 9'd255;
        end else begin
          rd_pos = rd_pos - 1;
        end
        expected_words.push_back(res_tbl[rd_pos[7:0]]);
      end
      default: ;
    endcase
  endfunction

  // called at a rising edge; returns at the edge where the beat was taken
  task automatic send_request(input req_e kind, input logic [7:0] idx,
                              input logic [31:0] word);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= kind;
    seed_index <= idx;
    seed_word <= word;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_request(kind, idx, word);
  endtask

  task automatic send_random(input req_e kind);
    send_request(kind, 8'($urandom), $urandom);
  endtask

  // register writes only with the block idle
  task automatic set_seed_len(input logic [31:0] value);
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= SeedWordsAddr;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    seed_len = value[8:0];
  endtask

  task automatic test_next_before_init();
    repeat (3) send_random(REQ_NEXT);
  endtask

  task automatic test_seed_extremes();
    send_request(REQ_SEED, 8'd0, 32'h0);
    send_request(REQ_SEED, 8'd255, 32'hffffffff);
    send_request(REQ_SEED, 8'd1, 32'hffffffff);
    send_request(REQ_SEED, 8'd254, 32'h0);
    send_request(REQ_SEED, 8'h55, 32'ha5a5a5a5);
    send_request(REQ_SEED, 8'haa, 32'h5a5a5a5a);
  endtask

  task automatic test_init_and_rewrite();
    send_random(REQ_INIT);
    repeat (3) send_random(REQ_NEXT);
    // overwrite a word that a later next returns unchanged
    send_request(REQ_SEED, 8'd252, 32'hdeadbeef);
    send_request(REQ_SEED, 8'd251, 32'h00000001);
    repeat (3) send_random(REQ_NEXT);
    send_random(REQ_NONE);
    send_random(REQ_NONE);
    send_random(REQ_NEXT);
  endtask

  task automatic test_refill_wrap(input logic [31:0] len);
    set_seed_len(len);
    for (int i = 0; i < 40; i++) send_request(REQ_SEED, 8'(i * 7), $urandom);
    send_random(REQ_INIT);
    quiet = 1'b1;
    repeat (100) send_random(REQ_NEXT);
    quiet = 1'b0;
    repeat (170) send_random(REQ_NEXT);
  endtask

  task automatic test_random_phase(input logic [31:0] len, input int count);
    int pick;
    set_seed_len(len);
    for (int i = 0; i < count; i++) begin
      if (i % 60 == 0) quiet = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 70) send_random(REQ_NEXT);
      else if (pick < 92) send_random(REQ_SEED);
      else if (pick < 96) send_random(REQ_INIT);
      else send_random(REQ_NONE);
    end
    quiet = 1'b0;
  endtask

  always @(posedge clk) begin
    if (out_valid && !out_stall) begin
      stall_left <= quiet ? 0 : $urandom_range(0, 14);
      if (expected_words.size() == 0) begin
        report($sformatf("unexpected word %h", random_word));
      end else begin
        if (random_word !== expected_words[0])
          report($sformatf("random_word %h, want %h", random_word, expected_words[0]));
        void'(expected_words.pop_front());
      end
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end
    out_stall <= (stall_left > 0);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("tb: errors");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < 256; i++) begin
      res_tbl[i] = '0;
      mix_tbl[i] = '0;
    end
    acc_a = '0;
    prev_b = '0;
    rounds = '0;
    rd_pos = '0;
    seed_len = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_next_before_init();
    test_seed_extremes();
    test_init_and_rewrite();
    test_refill_wrap(32'd256);
    test_random_phase(32'd0, 150);
    test_random_phase(32'd300, 150);
    test_random_phase(32'd1, 150);
    test_random_phase(32'd511, 150);
    test_random_phase(32'd137, 150);
    test_random_phase(32'd255, 150);
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end
endmodule

>>> files.f
rtl/isaac_pkg.sv
rtl/isaac_front.sv
rtl/isaac_back.sv
rtl/isaac_random_generator.sv
test/tb.sv
